// ===== hw/rtl/hrf_pkg.sv =====
// Package for the HTTP request framer: shared constants, codes, tables and types.
// No dependencies; http_request_framer and hrf_scan import it.
package hrf_pkg;

    // Width of the content length arithmetic.
    localparam int LEN_WIDTH = 32;
    // Width of the reported body length field.
    localparam int OUT_LEN_WIDTH = 32;

    // Length of the "content-length:" key.
    localparam logic [3:0] KEY_LEN = 4'd15;

    // Line scanner phases.
    localparam logic [1:0] PH_KEY    = 2'd0;
    localparam logic [1:0] PH_SPACE  = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_SKIP   = 2'd3;

    // Completion causes.
    localparam logic [1:0] CAUSE_NO_LENGTH = 2'd0;
    localparam logic [1:0] CAUSE_BODY      = 2'd1;
    localparam logic [1:0] CAUSE_CLOSED    = 2'd2;

    // Characters the scanner looks for.
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;

    // Lower-case key text, one character per index.
    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = "c";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "l";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            4'd14:   c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Header terminator CR LF CR LF, indexed by the number of characters matched.
    function automatic logic [7:0] term_char(input logic [1:0] idx);
        return idx[0] ? CHAR_LF : CHAR_CR;
    endfunction

    // One word handed to the scanner.
    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       conn_closed;
    } step_t;

    // The result word the scanner computes for a step.
    typedef struct packed {
        logic [7:0]               byte_out;
        logic                     in_body;
        logic                     request_done;
        logic [1:0]               done_cause;
        logic                     length_found;
        logic [OUT_LEN_WIDTH-1:0] body_length;
    } result_t;

endpackage

// ===== hw/rtl/hrf_in_if.sv =====
// Input channel of the HTTP request framer: valid/ready handshake with byte payload.
// Depends on nothing.
interface hrf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       conn_closed;

    modport source (output valid, output data_byte, output conn_closed, input ready);
    modport sink   (input valid, input data_byte, input conn_closed, output ready);
endinterface

// ===== hw/rtl/hrf_out_if.sv =====
// Output channel of the HTTP request framer: valid/ready handshake with tagged byte.
// Depends on nothing.
interface hrf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_out;
    logic        in_body;
    logic        request_done;
    logic [1:0]  done_cause;
    logic        length_found;
    logic [31:0] body_length;

    modport source (output valid, output byte_out, output in_body, output request_done,
                    output done_cause, output length_found, output body_length,
                    input ready);
    modport sink   (input valid, input byte_out, input in_body, input request_done,
                    input done_cause, input length_found, input body_length,
                    output ready);
endinterface

// ===== hw/rtl/http_request_framer.sv =====
// An accepted word is held in the input register; its result word is registered in the result register.
// Throughput: one word per cycle while the output is ready; the scanner state loop and the times-ten add set it.
// While a result waits, one more word is taken into the empty input register.
// Input ready follows output ready combinationally through the result register.
// Reset is asynchronous and active low; it empties both stages and idles the scanner.
// Depends on hrf_pkg, hrf_in_if, hrf_out_if and hrf_scan.
module http_request_framer
    import hrf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    hrf_in_if.sink   in_ch,
    hrf_out_if.source out_ch
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_closed_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;
    logic       advance;
    step_t      step;
    result_t    result;

    // Handshake: the result register frees up when empty or taken.
    assign advance        = !out_valid_reg || out_ch.ready;
    assign in_ch.ready    = !in_valid_reg || advance;
    assign in_valid_next  = in_ch.ready ? in_ch.valid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    // The held input word is scanned when the result register can take it.
    always_comb
    begin
        step.valid       = in_valid_reg && advance;
        step.data_byte   = in_byte_reg;
        step.conn_closed = in_closed_reg;
    end

    hrf_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .result (result)
    );

    // Valid flags of the input and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_byte_reg   <= in_ch.data_byte;
            in_closed_reg <= in_ch.conn_closed;
        end
        if (step.valid)
        begin
            out_reg <= result;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.byte_out     = out_reg.byte_out;
    assign out_ch.in_body      = out_reg.in_body;
    assign out_ch.request_done = out_reg.request_done;
    assign out_ch.done_cause   = out_reg.done_cause;
    assign out_ch.length_found = out_reg.length_found;
    assign out_ch.body_length  = out_reg.body_length;

`ifndef SYNTH
    // A stalled result word keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> out_valid_reg && $stable(out_reg))
        else $error("result word changed while stalled");

    // A scanned word always lands in the result register.
    a_step_lands: assert property (@(posedge clk) disable iff (!rst_n)
        step.valid |=> out_valid_reg)
        else $error("scanned word lost");

    // The input stage never drops a held word without scanning it.
    a_in_keep: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("held input word lost");
`endif

endmodule

// ===== hw/rtl/hrf_scan.sv =====
// Header scanner of the HTTP request framer: terminator match, content-length parse,
// body countdown. Depends on hrf_pkg.
module hrf_scan
    import hrf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  step_t   step,
    output result_t result
);

    logic [1:0]           term_reg, term_next;
    logic [1:0]           phase_reg, phase_next;
    logic [3:0]           key_reg, key_next;
    logic [LEN_WIDTH-1:0] acc_reg, acc_next;
    logic                 seen_reg, seen_next;
    logic                 ovf_reg, ovf_next;
    logic                 len_valid_reg, len_valid_next;
    logic [LEN_WIDTH-1:0] len_value_reg, len_value_next;
    logic                 header_done_reg, header_done_next;
    logic [LEN_WIDTH-1:0] remain_reg, remain_next;

    logic [7:0]                lc;
    logic                      is_digit;
    logic [LEN_WIDTH+3:0]      acc_wide;
    logic [LEN_WIDTH+3:0]      mul10;
    logic                      mul_ovf;
    logic                      prev_cr;
    logic [2:0]                match;
    logic [LEN_WIDTH-1:0]      remain_dec;
    logic                      done;
    logic [LEN_WIDTH+OUT_LEN_WIDTH-1:0] len_ext;

    // Per-byte helpers: lower case, digit test, times-ten accumulate, terminator match and body countdown.
    always_comb
    begin
        lc       = (step.data_byte >= CHAR_UP_A && step.data_byte <= CHAR_UP_Z)
                   ? (step.data_byte | 8'h20) : step.data_byte;
        is_digit = (step.data_byte >= CHAR_ZERO && step.data_byte <= CHAR_NINE);
        acc_wide = {4'b0000, acc_reg};
        mul10    = (acc_wide << 3) + (acc_wide << 1)
                   + {{(LEN_WIDTH){1'b0}}, step.data_byte[3:0]};
        mul_ovf  = |mul10[LEN_WIDTH+3:LEN_WIDTH];
        prev_cr  = term_reg[0];
        if (step.data_byte == term_char(term_reg))
        begin
            match = {1'b0, term_reg} + 3'd1;
        end
        else
        begin
            match = (step.data_byte == CHAR_CR) ? 3'd1 : 3'd0;
        end
        remain_dec = (remain_reg != '0) ? remain_reg - 1'b1 : remain_reg;
    end

    // Next state and result for one step.
    always_comb
    begin
        term_next        = term_reg;
        phase_next       = phase_reg;
        key_next         = key_reg;
        acc_next         = acc_reg;
        seen_next        = seen_reg;
        ovf_next         = ovf_reg;
        len_valid_next   = len_valid_reg;
        len_value_next   = len_value_reg;
        header_done_next = header_done_reg;
        remain_next      = remain_reg;
        done             = 1'b0;
        result.byte_out     = step.data_byte;
        result.in_body      = 1'b0;
        result.done_cause   = CAUSE_NO_LENGTH;

        if (step.conn_closed)
        begin
            result.byte_out   = 8'h00;
            done              = 1'b1;
            result.done_cause = CAUSE_CLOSED;
        end
        else if (header_done_reg)
        begin
            result.in_body = 1'b1;
            remain_next    = remain_dec;
            if (remain_dec == '0)
            begin
                done              = 1'b1;
                result.done_cause = CAUSE_BODY;
            end
        end
        else if (match == 3'd4)
        begin
            // Blank line: the header is complete.
            term_next = 2'd0;
            if (!len_valid_reg)
            begin
                done = 1'b1;
            end
            else if (len_value_reg == '0)
            begin
                done              = 1'b1;
                result.done_cause = CAUSE_BODY;
            end
            else
            begin
                header_done_next = 1'b1;
                remain_next      = len_value_reg;
            end
        end
        else
        begin
            term_next = match[1:0];
            if (step.data_byte == CHAR_LF && prev_cr)
            begin
                // CR LF starts a new header line.
                phase_next = PH_KEY;
                key_next   = 4'd0;
                acc_next   = '0;
                seen_next  = 1'b0;
                ovf_next   = 1'b0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_KEY:
                    begin
                        if (key_reg < KEY_LEN && lc == key_char(key_reg))
                        begin
                            key_next = key_reg + 4'd1;
                            if (key_reg + 4'd1 == KEY_LEN)
                            begin
                                phase_next = PH_SPACE;
                            end
                        end
                        else
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_SPACE, PH_DIGITS:
                    begin
                        if (phase_reg == PH_SPACE &&
                            (step.data_byte == CHAR_SPACE || step.data_byte == CHAR_TAB))
                        begin
                            phase_next = PH_SPACE;
                        end
                        else if (is_digit)
                        begin
                            phase_next = PH_DIGITS;
                            seen_next  = 1'b1;
                            if (!ovf_reg)
                            begin
                                if (mul_ovf)
                                begin
                                    ovf_next = 1'b1;
                                end
                                else
                                begin
                                    acc_next = mul10[LEN_WIDTH-1:0];
                                end
                            end
                        end
                        else
                        begin
                            // A non-digit ends the run; the first clean run sets the length.
                            if (phase_reg == PH_DIGITS && seen_reg && !ovf_reg
                                && !len_valid_reg)
                            begin
                                len_valid_next = 1'b1;
                                len_value_next = acc_reg;
                            end
                            phase_next = PH_SKIP;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_SKIP;
                    end
                endcase
            end
        end

        // Length fields report the parse result after this byte.
        len_ext             = {{(OUT_LEN_WIDTH){1'b0}}, len_value_next};
        result.request_done = done;
        result.length_found = len_valid_next;
        result.body_length  = len_valid_next ? len_ext[OUT_LEN_WIDTH-1:0] : '0;

        // Completion returns the scanner to idle.
        if (done)
        begin
            term_next        = 2'd0;
            phase_next       = PH_KEY;
            key_next         = 4'd0;
            acc_next         = '0;
            seen_next        = 1'b0;
            ovf_next         = 1'b0;
            len_valid_next   = 1'b0;
            len_value_next   = '0;
            header_done_next = 1'b0;
            remain_next      = '0;
        end
    end

    // State registers advance once per step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg        <= 2'd0;
            phase_reg       <= PH_KEY;
            key_reg         <= 4'd0;
            acc_reg         <= '0;
            seen_reg        <= 1'b0;
            ovf_reg         <= 1'b0;
            len_valid_reg   <= 1'b0;
            len_value_reg   <= '0;
            header_done_reg <= 1'b0;
            remain_reg      <= '0;
        end
        else if (step.valid)
        begin
            term_reg        <= term_next;
            phase_reg       <= phase_next;
            key_reg         <= key_next;
            acc_reg         <= acc_next;
            seen_reg        <= seen_next;
            ovf_reg         <= ovf_next;
            len_valid_reg   <= len_valid_next;
            len_value_reg   <= len_value_next;
            header_done_reg <= header_done_next;
            remain_reg      <= remain_next;
        end
    end

`ifndef SYNTH
    // A completed request leaves the scanner idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step.valid && result.request_done |=>
            !header_done_reg && !len_valid_reg && term_reg == 2'd0 && phase_reg == PH_KEY)
        else $error("scanner not idle after request completion");

    // While the body streams, bytes remain to be counted.
    a_body_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        header_done_reg |-> remain_reg != '0 && len_valid_reg)
        else $error("body phase with no bytes remaining");

    // A length is held only once it is marked valid.
    a_len_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !len_valid_reg |-> len_value_reg == '0)
        else $error("stale length value without valid length");

    // A cause other than header end without length comes only with completion.
    a_cause_done: assert property (@(posedge clk) disable iff (!rst_n)
        result.done_cause != CAUSE_NO_LENGTH |-> result.request_done)
        else $error("done cause set on an unfinished word");
`endif

endmodule
